FILE: sv/msi_pkg.sv
package msi_pkg;
	localparam int AXES = 8;
	localparam int RING_DEPTH = 8;
	localparam int ROW_LEN = AXES + 1;
	localparam int RING_WORDS = RING_DEPTH * ROW_LEN;
	localparam int RAW = $clog2(RING_WORDS);
	localparam int ROWW = $clog2(RING_DEPTH);
	localparam int AXW = $clog2(AXES);
	localparam int ELW = $clog2(ROW_LEN);
	localparam int QW = $clog2(RING_DEPTH + 1);
	localparam logic [15:0] RESET_DURATION = 16'd1000;
	localparam logic [15:0] RESET_POSITION = 16'd1500;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_WRITE = 2'd1,
		OP_COMMIT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_TICK = 2'd0,
		REG_SNAP = 2'd1,
		REG_LWM = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LRD0, S_LRD1, S_LRD2, S_LRD3, S_LDIV, S_LWAIT,
		S_TRD, S_TRD2, S_TMUL, S_TSUM, S_TEND, S_TOUT
	} state_t;

	// divider request and result
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic [RAW-1:0] ring_addr(input logic [ROWW-1:0] row,
		input logic [ELW-1:0] el);
		logic [RAW+ELW:0] t;
		t = (RAW+ELW+1)'(row) * (RAW+ELW+1)'(ROW_LEN) + (RAW+ELW+1)'(el);
		return t[RAW-1:0];
	endfunction
endpackage

FILE: sv/msi_ram.sv
module msi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/msi_div.sv
module msi_div
	import msi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;

	always_comb begin
		trial = {rem_q[15:0], quo_q[31]};
		diff = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[16]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quo_q};
endmodule

FILE: sv/multi_axis_servo_interpolator.sv
// Servo pose interpolator. Write and commit requests are taken while idle. An
// idle tick that loads the next queued row reads the duration and runs one
// 32-step division for the step count, then per axis reads target and start
// from the pose ring memory and runs one division for the increment. A busy
// tick first walks the eight axes, each through two ring reads, the registered
// multiply and the clamp, then settles the segment state and hands out one
// result per axis per cycle while the receiver does not stall. The output
// register holds a result while the receiver stalls, and the input stays
// stalled until the last result of the tick has been loaded. After reset a
// clearing pass writes the reset pose into all ring words (one word a cycle)
// before the first request is accepted.
module multi_axis_servo_interpolator
	import msi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [3:0]  element_index,
	input  logic [15:0] element_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  axis_number,
	output logic [15:0] pulse_width,
	output logic        last_axis,
	output logic        time_up,
	output logic        segment_idle,
	output logic        space_available
);
	state_t state_q, state_d;
	logic [7:0] tick_q, snap_q;
	logic [3:0] lwm_q;
	logic [ROWW-1:0] cur_row_q, tgt_row_q, wr_row_q;
	logic [QW-1:0] queued_q;
	logic [15:0] steps_total_q, steps_done_q;
	logic fin_q, tover_q, arr_q, tup_q;
	logic [AXW:0] axis_q;
	logic [RAW-1:0] clr_q;
	logic [ELW-1:0] clr_el_q;
	logic [15:0] from_q, to_q;
	logic mag_pos_q;
	logic [AXW:0] arrived_cnt_q;
	logic signed [31:0] inc_q [AXES];
	logic [15:0] pos_q [AXES];
	logic signed [48:0] prod_s1;
	logic snap_hit_s1;

	// ring memory
	logic ram_we;
	logic [RAW-1:0] ram_wa, ram_ra;
	logic [15:0] ram_wd, ram_rd;
	msi_ram #(.WIDTH(16), .DEPTH(RING_WORDS)) u_ring (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	div_req_t dreq;
	div_rsp_t drsp;
	msi_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic full, acc, cfg_wr, out_load, last_ax;
	logic [AXW-1:0] ax;
	logic [15:0] per16;
	assign ax = axis_q[AXW-1:0];
	assign last_ax = (axis_q == (AXW+1)'(AXES - 1));
	assign full = queued_q >= QW'(RING_DEPTH - 2);
	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign per16 = (tick_q == 8'd0) ? 16'd1 : {8'd0, tick_q};
	assign out_load = (state_q == S_TOUT) && (!out_valid || !out_stall);

	always_comb begin
		case (paddr[3:2])
			REG_TICK: prdata = {24'd0, tick_q};
			REG_SNAP: prdata = {24'd0, snap_q};
			REG_LWM:  prdata = {28'd0, lwm_q};
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 8'd20;
			snap_q <= 8'd5;
			lwm_q <= 4'd5;
		end else if (cfg_wr && paddr[1:0] == 2'd0) begin
			case (paddr[3:2])
				REG_TICK: tick_q <= pwdata[7:0];
				REG_SNAP: snap_q <= pwdata[7:0];
				REG_LWM:  lwm_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// offset floor and clamp
	logic signed [48:0] prod_c;
	logic signed [33:0] off_c;
	logic signed [34:0] sum_c;
	logic [15:0] sum_sat;
	logic [15:0] dist_c;
	always_comb begin
		prod_c = $signed({1'b0, steps_done_q}) * inc_q[ax];
		off_c = 34'(prod_s1 >>> 16);
		sum_c = $signed({19'd0, from_q}) + 35'(off_c);
		if (sum_c < 0) sum_sat = 16'd0;
		else if (sum_c > 35'sd65535) sum_sat = 16'hFFFF;
		else sum_sat = sum_c[15:0];
		dist_c = (pos_q[ax] > ram_rd) ? pos_q[ax] - ram_rd : ram_rd - pos_q[ax];
	end

	// start word is on the read port while in S_LDIV
	logic [15:0] mag_c;
	assign mag_c = (to_q > ram_rd) ? to_q - ram_rd : ram_rd - to_q;

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_wa = ring_addr(wr_row_q, element_index[ELW-1:0]);
		ram_wd = element_value;
		ram_ra = ring_addr(tgt_row_q, '0);
		dreq.start = 1'b0;
		dreq.dividend = {16'd0, ram_rd};
		dreq.divisor = per16;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = (clr_el_q == '0) ? RESET_DURATION : RESET_POSITION;
				if (clr_q == RAW'(RING_WORDS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc) begin
					case (operation)
						OP_WRITE: ram_we = !full && element_index <= 4'(AXES);
						OP_TICK: begin
							if (!fin_q) begin
								state_d = S_TRD;
							end else if (queued_q != '0) begin
								state_d = S_LRD0;
							end
						end
						default: ;
					endcase
				end
			end
			S_LRD0: begin
				ram_ra = ring_addr(tgt_row_q, '0);
				state_d = S_LRD1;
			end
			S_LRD1: begin
				dreq.start = 1'b1;
				dreq.dividend = {16'd0, ram_rd};
				state_d = S_LWAIT;
			end
			S_LWAIT: begin
				if (drsp.done) state_d = (ld_phase_q && last_ax) ? S_IDLE : S_LRD2;
			end
			S_LRD2: begin
				ram_ra = ring_addr(tgt_row_q, ELW'(ax + 1));
				state_d = S_LRD3;
			end
			S_LRD3: begin
				ram_ra = ring_addr(cur_row_q, ELW'(ax + 1));
				state_d = S_LDIV;
			end
			S_LDIV: begin
				dreq.start = 1'b1;
				dreq.dividend = {mag_c, 16'd0};
				dreq.divisor = steps_total_q;
				state_d = S_LWAIT;
			end
			S_TRD: begin
				ram_ra = ring_addr(tgt_row_q, ELW'(ax + 1));
				state_d = S_TRD2;
			end
			S_TRD2: begin
				ram_ra = ring_addr(cur_row_q, ELW'(ax + 1));
				state_d = S_TMUL;
			end
			S_TMUL: state_d = S_TSUM;
			S_TSUM: state_d = last_ax ? S_TEND : S_TRD;
			S_TEND: state_d = S_TOUT;
			S_TOUT: begin
				if (out_load) state_d = last_ax ? S_IDLE : S_TOUT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	logic ld_phase_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			clr_el_q <= '0;
			cur_row_q <= '0;
			tgt_row_q <= ROWW'(1 % RING_DEPTH);
			wr_row_q <= ROWW'(2 % RING_DEPTH);
			queued_q <= '0;
			steps_total_q <= RESET_DURATION;
			steps_done_q <= 16'd1;
			fin_q <= 1'b1;
			tover_q <= 1'b0;
			arr_q <= 1'b0;
			tup_q <= 1'b0;
			axis_q <= '0;
			ld_phase_q <= 1'b0;
			out_valid <= 1'b0;
			arrived_cnt_q <= '0;
			for (int i = 0; i < AXES; i++) begin
				inc_q[i] <= '0;
				pos_q[i] <= RESET_POSITION;
			end
		end else begin
			state_q <= state_d;
			out_valid <= out_load || (out_valid && out_stall);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + RAW'(1);
					clr_el_q <= (clr_el_q == ELW'(ROW_LEN - 1)) ? '0 : clr_el_q + ELW'(1);
				end
				S_IDLE: begin
					if (acc && operation == OP_COMMIT && !full) begin
						queued_q <= queued_q + QW'(1);
						wr_row_q <= (wr_row_q == ROWW'(RING_DEPTH - 1)) ? '0 : wr_row_q + ROWW'(1);
					end
					if (acc && operation == OP_TICK) begin
						axis_q <= '0;
						arrived_cnt_q <= '0;
						if (!fin_q) begin
							logic [15:0] nd;
							nd = (steps_done_q != 16'hFFFF) ? steps_done_q + 16'd1 : steps_done_q;
							steps_done_q <= nd;
							tup_q <= (nd == steps_total_q);
							if (nd == steps_total_q) tover_q <= 1'b1;
						end else if (queued_q != '0) begin
							queued_q <= queued_q - QW'(1);
							cur_row_q <= (cur_row_q == ROWW'(RING_DEPTH - 1)) ? '0 : cur_row_q + ROWW'(1);
							tgt_row_q <= (tgt_row_q == ROWW'(RING_DEPTH - 1)) ? '0 : tgt_row_q + ROWW'(1);
							ld_phase_q <= 1'b0;
						end
					end
				end
				S_LWAIT: begin
					if (drsp.done) begin
						if (!ld_phase_q) begin
							steps_total_q <= (drsp.quotient[15:0] == 16'd0) ? 16'd1 : drsp.quotient[15:0];
							ld_phase_q <= 1'b1;
						end else begin
							logic [31:0] q;
							q = drsp.quotient[31] ? 32'h7FFFFFFF : drsp.quotient;
							inc_q[ax] <= mag_pos_q ? $signed(q) : -$signed(q);
							axis_q <= axis_q + (AXW+1)'(1);
							if (last_ax) begin
								steps_done_q <= '0;
								fin_q <= 1'b0;
							end
						end
					end
				end
				S_LRD3: to_q <= ram_rd;
				// keep the direction for the sign of the increment
				S_LDIV: mag_pos_q <= (to_q > ram_rd);
				S_TRD2: begin
					to_q <= ram_rd;
					snap_hit_s1 <= dist_c < {8'd0, snap_q};
				end
				S_TMUL: begin
					from_q <= ram_rd;
					prod_s1 <= prod_c;
				end
				S_TSUM: begin
					if (snap_hit_s1) begin
						pos_q[ax] <= to_q;
						arrived_cnt_q <= arrived_cnt_q + (AXW+1)'(1);
					end else begin
						pos_q[ax] <= sum_sat;
					end
					if (!last_ax) axis_q <= axis_q + (AXW+1)'(1);
				end
				S_TEND: begin
					logic na;
					na = arr_q || (arrived_cnt_q == (AXW+1)'(AXES));
					axis_q <= '0;
					if (tover_q && na) begin
						fin_q <= 1'b1;
						tover_q <= 1'b0;
						arr_q <= 1'b0;
					end else begin
						arr_q <= na;
					end
				end
				S_TOUT: begin
					if (out_load) begin
						axis_number <= 3'(ax);
						pulse_width <= pos_q[ax];
						last_axis <= last_ax;
						time_up <= tup_q;
						segment_idle <= fin_q;
						space_available <= {{(5-QW){1'b0}}, queued_q} < {1'b0, lwm_q};
						if (!last_ax) axis_q <= axis_q + (AXW+1)'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOUT && !out_stall) |=> out_valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		queued_q <= QW'(RING_DEPTH - 2))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(pulse_width))
		else $error("stalled result changed");
endmodule
